// File: sv/bpsm_pkg.sv
// Shared constants, types and phi helpers for the best phi segment match unit.
package bpsm_pkg;

  localparam int HISTORY_DEPTH      = 3;
  localparam int CHAMBERS           = 3;
  localparam int SEGS_PER_CHAMBER   = 2;
  localparam int PHI_BITS           = 13;
  localparam int PAT_PHI_BITS       = 8;
  localparam int THETA_BITS         = 7;
  localparam int THETAS_PER_CHAMBER = 2;

  localparam int NCELL     = HISTORY_DEPTH * CHAMBERS;
  localparam int HIST_W    = 2;
  localparam int CHAM_W    = 2;
  localparam int PATTERN_W = 4;
  localparam int QUAL_W    = 6;
  localparam int MASK_W    = 2;
  localparam int DIFF_W    = 5;

  localparam logic [DIFF_W-1:0] DIFF_LIMIT = 5'd7;
  localparam logic [DIFF_W-1:0] DIFF_NONE  = 5'd15;
  localparam logic [DIFF_W-1:0] DIFF_START = 5'd16;

  typedef struct packed {
    logic [HIST_W-1:0]     hist;
    logic [CHAM_W-1:0]     cham;
    logic                  seg;
    logic [PHI_BITS-1:0]   phi;
    logic                  valid;
    logic [THETA_BITS-1:0] theta;
    logic [PATTERN_W-1:0]  pattern;
  } load_t;

  typedef struct packed {
    logic [PAT_PHI_BITS-1:0] pat;
    logic                    pat_ok;
    logic [DIFF_W-1:0]       best;
    logic [HIST_W-1:0]       hist;
    logic [CHAM_W-1:0]       cham;
    logic                    seg;
    logic [PHI_BITS-1:0]     phi;
    logic [THETA_BITS-1:0]   theta_first;
    logic [THETA_BITS-1:0]   theta_second;
    logic [PATTERN_W-1:0]    pattern;
    logic [MASK_W-1:0]       vmask;
  } token_t;

  // Align a full phi to the pattern phi precision (drop or pad low bits).
  function automatic logic [PAT_PHI_BITS-1:0] reduce_phi(input logic [PHI_BITS-1:0] phi);
    logic [PHI_BITS+PAT_PHI_BITS-1:0] w;
    w = {phi, {PAT_PHI_BITS{1'b0}}} >> PHI_BITS;
    return w[PAT_PHI_BITS-1:0];
  endfunction

  // Absolute phi distance, saturated to the no-match code beyond the window.
  function automatic logic [DIFF_W-1:0] phi_diff(input logic [PAT_PHI_BITS-1:0] pat,
                                                input logic [PHI_BITS-1:0]     phi);
    logic [PAT_PHI_BITS-1:0] r;
    logic [PAT_PHI_BITS-1:0] a;
    r = reduce_phi(phi);
    a = (pat > r) ? (pat - r) : (r - pat);
    if (a > PAT_PHI_BITS'(DIFF_LIMIT)) begin
      return DIFF_NONE;
    end
    return DIFF_W'(a);
  endfunction

endpackage

// File: sv/bpsm_cell.sv
// One chamber cell: holds its segments and thetas, updates the passing best-match token.
module bpsm_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bpsm_pkg::HIST_W-1:0]   cell_hist_i,
  input  logic [bpsm_pkg::CHAM_W-1:0]   cell_cham_i,
  input  logic                          ld_en_i,
  input  bpsm_pkg::load_t               ld_i,
  input  logic                          tok_vld_i,
  input  bpsm_pkg::token_t              tok_i,
  output logic                          tok_vld_o,
  output bpsm_pkg::token_t              tok_o
);
  import bpsm_pkg::*;

  logic [PHI_BITS-1:0]   phi_q     [SEGS_PER_CHAMBER];
  logic                  valid_q   [SEGS_PER_CHAMBER];
  logic [PATTERN_W-1:0]  pattern_q [SEGS_PER_CHAMBER];
  logic [THETA_BITS-1:0] theta_q   [THETAS_PER_CHAMBER];

  logic                  hit;
  logic [DIFF_W-1:0]     diff      [SEGS_PER_CHAMBER];
  logic [MASK_W-1:0]     vmask;
  token_t                tok_d;
  token_t                tok_q;
  logic                  tok_vld_q;

  assign hit = ld_en_i && (ld_i.hist == cell_hist_i) && (ld_i.cham == cell_cham_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SEGS_PER_CHAMBER; s++) begin
        phi_q[s]     <= '0;
        valid_q[s]   <= 1'b0;
        pattern_q[s] <= '0;
      end
      for (int t = 0; t < THETAS_PER_CHAMBER; t++) begin
        theta_q[t] <= '0;
      end
    end else if (hit) begin
      // theta entry is written even when the segment index has no slot
      for (int t = 0; t < THETAS_PER_CHAMBER; t++) begin
        if (ld_i.seg == 1'(t)) begin
          theta_q[t] <= ld_i.theta;
        end
      end
      for (int s = 0; s < SEGS_PER_CHAMBER; s++) begin
        if (ld_i.seg == 1'(s)) begin
          phi_q[s]     <= ld_i.phi;
          valid_q[s]   <= ld_i.valid;
          pattern_q[s] <= ld_i.pattern;
        end
      end
    end
  end

  always_comb begin
    vmask = '0;
    for (int s = 0; s < SEGS_PER_CHAMBER; s++) begin
      vmask[s] = valid_q[s];
      diff[s]  = valid_q[s] ? phi_diff(tok_i.pat, phi_q[s]) : DIFF_NONE;
    end
  end

  // Ties go to the later slot, hence <=.
  always_comb begin
    tok_d = tok_i;
    for (int s = 0; s < SEGS_PER_CHAMBER; s++) begin
      if (diff[s] <= tok_d.best) begin
        tok_d.best         = diff[s];
        tok_d.hist         = cell_hist_i;
        tok_d.cham         = cell_cham_i;
        tok_d.seg          = 1'(s);
        tok_d.phi          = phi_q[s];
        tok_d.pattern      = pattern_q[s];
        tok_d.theta_first  = theta_q[0];
        tok_d.theta_second = theta_q[1];
        tok_d.vmask        = vmask;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

// File: sv/best_phi_segment_match_unit.sv
// Top level of the best phi segment match unit: input decode, cell chain, result register.
//
// Input channel (in_valid_i / in_stall_o) carries two kinds of beat. A load beat
// (req_type_i = 0) writes one segment slot and its theta into the chamber cell
// addressed by hist_slot_i and chamber_slot_i; it gives no result. An address
// beyond the stored chambers is dropped.
// A match beat (req_type_i = 1) launches a token down a chain of NCELL chamber
// cells, one cell per cycle; each cell folds its segments into the running best.
// The match beat is registered into the start token, then passes through the NCELL
// cell registers and into the result register, where the result beat shows.
// One match is in flight at a time, so a new match waits until the token leaves the
// chain, while loads are taken every cycle the chain is empty.
// The output is a register: while a result waits (out_stall_i high) loads are
// still taken, a new match is held off until the result beat goes out.
// Reset clears all stored slots and thetas to zero and empties the chain.
module best_phi_segment_match_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [1:0]                          hist_slot_i,
  input  logic [1:0]                          chamber_slot_i,
  input  logic                                seg_slot_i,
  input  logic [bpsm_pkg::PHI_BITS-1:0]       seg_phi_i,
  input  logic                                seg_valid_i,
  input  logic [bpsm_pkg::THETA_BITS-1:0]     seg_theta_i,
  input  logic [3:0]                          seg_pattern_i,
  input  logic [bpsm_pkg::PAT_PHI_BITS-1:0]   pat_phi_i,
  input  logic [5:0]                          pat_quality_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          valid_mask_o,
  output logic [1:0]                          hist_id_o,
  output logic [1:0]                          chamber_id_o,
  output logic                                seg_id_o,
  output logic [bpsm_pkg::PHI_BITS-1:0]       phi_match_o,
  output logic [bpsm_pkg::THETA_BITS-1:0]     theta_first_o,
  output logic [bpsm_pkg::THETA_BITS-1:0]     theta_second_o,
  output logic [3:0]                          pattern_match_o
);
  import bpsm_pkg::*;

  logic              in_take;
  logic              ld_en;
  logic              match_take;
  load_t             ld;
  logic              busy_q;
  logic              st_vld_q;
  token_t            st_d;
  token_t            st_q;
  logic [NCELL:0]    chain_vld;
  token_t            chain_tok [NCELL+1];
  logic              last_vld;
  token_t            last_tok;
  logic              out_valid_q;
  token_t            out_q;
  logic [MASK_W-1:0] out_mask_q;

  assign in_stall_o = busy_q || (out_valid_q && req_type_i);
  assign in_take    = in_valid_i && !in_stall_o;
  assign ld_en      = in_take && !req_type_i;
  assign match_take = in_take && req_type_i;

  assign ld.hist    = hist_slot_i;
  assign ld.cham    = chamber_slot_i;
  assign ld.seg     = seg_slot_i;
  assign ld.phi     = seg_phi_i;
  assign ld.valid   = seg_valid_i;
  assign ld.theta   = seg_theta_i;
  assign ld.pattern = seg_pattern_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= match_take;
    end
  end

  always_comb begin
    st_d        = '0;
    st_d.pat    = pat_phi_i;
    st_d.pat_ok = (pat_quality_i != '0);
    st_d.best   = DIFF_START;
  end

  always_ff @(posedge clk_i) begin
    if (match_take) begin
      st_q <= st_d;
    end
  end

  assign chain_vld[0] = st_vld_q;
  assign chain_tok[0] = st_q;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    localparam logic [HIST_W-1:0] CellHist = HIST_W'(g / CHAMBERS);
    localparam logic [CHAM_W-1:0] CellCham = CHAM_W'(g % CHAMBERS);

    bpsm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_hist_i (CellHist),
      .cell_cham_i (CellCham),
      .ld_en_i     (ld_en),
      .ld_i        (ld),
      .tok_vld_i   (chain_vld[g]),
      .tok_i       (chain_tok[g]),
      .tok_vld_o   (chain_vld[g+1]),
      .tok_o       (chain_tok[g+1])
    );
  end

  assign last_vld = chain_vld[NCELL];
  assign last_tok = chain_tok[NCELL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (match_take) begin
        busy_q <= 1'b1;
      end else if (last_vld) begin
        busy_q <= 1'b0;
      end
      if (last_vld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Drop the mask for an invalid pattern or when nothing fell in the window.
  always_ff @(posedge clk_i) begin
    if (last_vld) begin
      out_q      <= last_tok;
      out_mask_q <= (last_tok.pat_ok && (last_tok.best != DIFF_NONE)) ? last_tok.vmask : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign valid_mask_o    = out_mask_q;
  assign hist_id_o       = out_q.hist;
  assign chamber_id_o    = out_q.cham;
  assign seg_id_o        = out_q.seg;
  assign phi_match_o     = out_q.phi;
  assign theta_first_o   = out_q.theta_first;
  assign theta_second_o  = out_q.theta_second;
  assign pattern_match_o = out_q.pattern;

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one match token in the cell chain");

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_vld != '0) |-> (busy_q && in_stall_o))
    else $error("input taken while a match token is in flight");

  a_result_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last_vld))
    else $error("result raised without a token leaving the chain");

  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_q)
    else $error("match finished without a result beat");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_vld |-> !out_valid_q)
    else $error("result register overwritten before its beat went out");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the best phi segment match unit: loads, match queries, handshakes.
module testbench;
  import bpsm_pkg::*;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  localparam int NSLOT     = HISTORY_DEPTH * CHAMBERS * SEGS_PER_CHAMBER;
  localparam int PHI_DROP  = (PHI_BITS > PAT_PHI_BITS) ? PHI_BITS - PAT_PHI_BITS : 0;
  localparam int PHI_PAD   = (PAT_PHI_BITS > PHI_BITS) ? PAT_PHI_BITS - PHI_BITS : 0;
  localparam int PAT_MAX   = (1 << PAT_PHI_BITS) - 1;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic                    req;
    logic [1:0]              hist;
    logic [1:0]              cham;
    logic                    seg;
    logic [PHI_BITS-1:0]     phi;
    logic                    valid;
    logic [THETA_BITS-1:0]   theta;
    logic [3:0]              pattern;
    logic [PAT_PHI_BITS-1:0] pat;
    logic [5:0]              qual;
  } beat_t;

  typedef struct packed {
    logic [1:0]            mask;
    logic [1:0]            hist;
    logic [1:0]            cham;
    logic                  seg;
    logic [PHI_BITS-1:0]   phi;
    logic [THETA_BITS-1:0] theta_first;
    logic [THETA_BITS-1:0] theta_second;
    logic [3:0]            pattern;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  beat_t cur_beat = '0;

  logic [1:0]              valid_mask;
  logic [1:0]              hist_id;
  logic [1:0]              chamber_id;
  logic                    seg_id;
  logic [PHI_BITS-1:0]     phi_match;
  logic [THETA_BITS-1:0]   theta_first;
  logic [THETA_BITS-1:0]   theta_second;
  logic [3:0]              pattern_match;

  // Table copy held by the predictor
  logic [PHI_BITS-1:0]   slot_phi     [NSLOT];
  logic                  slot_valid   [NSLOT];
  logic [3:0]            slot_pattern [NSLOT];
  logic [THETA_BITS-1:0] cham_theta   [HISTORY_DEPTH*CHAMBERS*THETAS_PER_CHAMBER];

  beat_t  beat_q[$];
  match_t pending_match_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_req = 1'b0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int idle_cycles = 0;

  int errors = 0;
  int n_load = 0;
  int n_dropped = 0;
  int n_match = 0;
  int n_hit = 0;
  int n_miss = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  best_phi_segment_match_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (cur_beat.req),
    .hist_slot_i    (cur_beat.hist),
    .chamber_slot_i (cur_beat.cham),
    .seg_slot_i     (cur_beat.seg),
    .seg_phi_i      (cur_beat.phi),
    .seg_valid_i    (cur_beat.valid),
    .seg_theta_i    (cur_beat.theta),
    .seg_pattern_i  (cur_beat.pattern),
    .pat_phi_i      (cur_beat.pat),
    .pat_quality_i  (cur_beat.qual),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .valid_mask_o   (valid_mask),
    .hist_id_o      (hist_id),
    .chamber_id_o   (chamber_id),
    .seg_id_o       (seg_id),
    .phi_match_o    (phi_match),
    .theta_first_o  (theta_first),
    .theta_second_o (theta_second),
    .pattern_match_o(pattern_match)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  function automatic logic dropped_load(input beat_t b);
    return b.req == REQ_LOAD && (b.hist >= HISTORY_DEPTH || b.cham >= CHAMBERS);
  endfunction

  // Scan every slot; the closest phi wins, the later slot on a tie.
  function automatic match_t find_best(input beat_t b);
    match_t m;
    int best, d, r, k, ch;
    best = int'(DIFF_NONE) + 1;
    k = 0;
    for (int i = 0; i < NSLOT; i++) begin
      d = int'(DIFF_NONE);
      if (slot_valid[i]) begin
        r = ((int'(slot_phi[i]) >> PHI_DROP) << PHI_PAD) & PAT_MAX;
        d = (int'(b.pat) > r) ? int'(b.pat) - r : r - int'(b.pat);
        if (d > int'(DIFF_LIMIT)) d = int'(DIFF_NONE);
      end
      if (d <= best) begin
        best = d;
        k = i;
      end
    end
    ch = k / SEGS_PER_CHAMBER;
    m.mask = '0;
    for (int s = 0; s < SEGS_PER_CHAMBER; s++)
      m.mask |= 2'(slot_valid[ch*SEGS_PER_CHAMBER + s]) << s;
    if (b.qual == 0 || best == int'(DIFF_NONE)) m.mask = '0;
    m.hist = 2'(ch / CHAMBERS);
    m.cham = 2'(ch % CHAMBERS);
    m.seg = 1'(k % SEGS_PER_CHAMBER);
    m.phi = slot_phi[k];
    m.theta_first = cham_theta[ch*THETAS_PER_CHAMBER];
    m.theta_second = cham_theta[ch*THETAS_PER_CHAMBER + 1];
    m.pattern = slot_pattern[k];
    return m;
  endfunction

  task automatic apply_beat(input beat_t b);
    int ch, k;
    match_t m;
    if (b.req == REQ_MATCH) begin
      m = find_best(b);
      pending_match_q.push_back(m);
      n_match++;
      if (m.mask != 0) n_hit++;
      else n_miss++;
    end else if (dropped_load(b)) begin
      n_dropped++;
    end else begin
      n_load++;
      ch = int'(b.hist) * CHAMBERS + int'(b.cham);
      cham_theta[ch*THETAS_PER_CHAMBER + int'(b.seg)] = b.theta;
      if (b.seg < SEGS_PER_CHAMBER) begin
        k = ch * SEGS_PER_CHAMBER + int'(b.seg);
        slot_phi[k] = b.phi;
        slot_valid[k] = b.valid;
        slot_pattern[k] = b.pattern;
      end
    end
  endtask

  task automatic check_result();
    match_t m;
    if (pending_match_q.size() == 0) begin
      report_mismatch("result beat with no match pending", int'(hist_id), -1);
    end else begin
      m = pending_match_q.pop_front();
      if (valid_mask != m.mask)
        report_mismatch("valid_mask", int'(valid_mask), int'(m.mask));
      if (hist_id != m.hist) report_mismatch("hist_id", int'(hist_id), int'(m.hist));
      if (chamber_id != m.cham)
        report_mismatch("chamber_id", int'(chamber_id), int'(m.cham));
      if (seg_id != m.seg) report_mismatch("seg_id", int'(seg_id), int'(m.seg));
      if (phi_match != m.phi) report_mismatch("phi_match", int'(phi_match), int'(m.phi));
      if (theta_first != m.theta_first)
        report_mismatch("theta_first", int'(theta_first), int'(m.theta_first));
      if (theta_second != m.theta_second)
        report_mismatch("theta_second", int'(theta_second), int'(m.theta_second));
      if (pattern_match != m.pattern)
        report_mismatch("pattern_match", int'(pattern_match), int'(m.pattern));
    end
  endtask

  // Driver: hold the beat while stalled, advance after each accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) apply_beat(cur_beat);
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_beat <= beat_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result beats and drive the output stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) check_result();
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (long_hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic beat_t rand_beat();
    logic [63:0] r;
    beat_t b;
    r = {$urandom, $urandom};
    b = r[$bits(beat_t)-1:0];
    return b;
  endfunction

  function automatic beat_t load_beat(input int h, input int c, input int s, input int phi,
                                      input int v, input int th, input int pt);
    beat_t b;
    b = rand_beat();
    b.req = REQ_LOAD;
    b.hist = 2'(h);
    b.cham = 2'(c);
    b.seg = 1'(s);
    b.phi = PHI_BITS'(phi);
    b.valid = 1'(v);
    b.theta = THETA_BITS'(th);
    b.pattern = 4'(pt);
    return b;
  endfunction

  function automatic beat_t match_beat(input int pat, input int q);
    beat_t b;
    b = rand_beat();
    b.req = REQ_MATCH;
    b.pat = PAT_PHI_BITS'(pat);
    b.qual = 6'(q);
    return b;
  endfunction

  // Mostly a burst of loads clustered around one phi, then queries near it; some noise.
  task automatic add_group(inout int counted);
    int base, loads, queries, tgt;
    beat_t b;
    base = $urandom_range(0, PAT_MAX);
    loads = $urandom_range(1, 8);
    queries = $urandom_range(1, 4);
    if ($urandom_range(0, 99) < 12) begin
      repeat (loads + queries) begin
        b = rand_beat();
        beat_q.push_back(b);
        if (!dropped_load(b)) counted++;
      end
    end else begin
      repeat (loads) begin
        b = rand_beat();
        b.req = REQ_LOAD;
        if ($urandom_range(0, 99) < 92) begin
          b.hist = 2'($urandom_range(0, HISTORY_DEPTH - 1));
          b.cham = 2'($urandom_range(0, CHAMBERS - 1));
        end
        tgt = (base + $urandom_range(0, 18) - 9) & PAT_MAX;
        b.phi = PHI_BITS'((tgt << PHI_DROP) >> PHI_PAD)
              | PHI_BITS'($urandom & ((1 << PHI_DROP) - 1));
        b.valid = ($urandom_range(0, 99) < 85);
        beat_q.push_back(b);
        if (!dropped_load(b)) counted++;
      end
      repeat (queries) begin
        b = rand_beat();
        b.req = REQ_MATCH;
        b.pat = PAT_PHI_BITS'(base + $urandom_range(0, 14) - 7);
        if ($urandom_range(0, 99) < 15) b.qual = '0;
        beat_q.push_back(b);
        counted++;
      end
    end
  endtask

  task automatic run_phase(input int n_items);
    int counted;
    counted = 0;
    while (counted < n_items) add_group(counted);
    while (beat_q.size() != 0 || in_valid || pending_match_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_phi[i] = '0;
      slot_valid[i] = 1'b0;
      slot_pattern[i] = '0;
    end
    foreach (cham_theta[i]) cham_theta[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, extremes, dropped loads, ties, window edge
    beat_q.push_back(match_beat(128, 63));
    beat_q.push_back(load_beat(0, 0, 0, 13'h1FFF, 1, 127, 15));
    beat_q.push_back(load_beat(0, 0, 1, 0, 0, 0, 0));
    beat_q.push_back(match_beat(255, 63));
    beat_q.push_back(match_beat(255, 0));
    beat_q.push_back(load_beat(3, 0, 0, 13'h1FFF, 1, 5, 5));
    beat_q.push_back(load_beat(0, 3, 1, 13'h1FFF, 1, 6, 6));
    beat_q.push_back(load_beat(3, 3, 0, 13'h1FFF, 1, 7, 7));
    beat_q.push_back(match_beat(255, 1));
    beat_q.push_back(load_beat(2, 2, 1, 13'h1FE0, 1, 64, 9));
    beat_q.push_back(load_beat(2, 2, 0, 0, 0, 33, 1));
    beat_q.push_back(match_beat(255, 63));
    beat_q.push_back(load_beat(1, 1, 0, 13'h001F, 1, 100, 3));
    beat_q.push_back(match_beat(7, 63));
    beat_q.push_back(match_beat(8, 63));
    beat_q.push_back(match_beat(0, 63));
    beat_q.push_back(load_beat(1, 1, 1, 13'h0040, 1, 7, 12));
    beat_q.push_back(match_beat(1, 42));
    beat_q.push_back(load_beat(0, 0, 0, 13'h1FFF, 0, 0, 0));
    beat_q.push_back(match_beat(250, 63));
    run_phase(0);

    send_idle_pct = 16;
    recv_stall_pct = 68;
    run_phase(450);

    send_idle_pct = 68;
    recv_stall_pct = 16;
    run_phase(450);

    // Hold the output for a long stretch while the sender keeps offering beats
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b1;
    run_phase(400);

    repeat (NCELL + 6) @(negedge clk_i);
    if (pending_match_q.size() != 0)
      report_mismatch("match results never delivered", 0, pending_match_q.size());

    $display("Covered %0d loads (%0d dropped out of range) and %0d match queries,",
             n_load, n_dropped, n_match);
    $display("  %0d with a hit and %0d without, under both stall mixes and a %0d-cycle hold.",
             n_hit, n_miss, LONG_HOLD);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bpsm_pkg.sv
sv/bpsm_cell.sv
sv/best_phi_segment_match_unit.sv
tb/testbench.sv
